>>> rtl/core/rcw_pkg.sv
`timescale 1ns / 1ps
package rcw_pkg;

  localparam int unsigned FACE_W   = 10;
  localparam int unsigned VAL_W    = 48;
  localparam int unsigned REG_W    = 47;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned NUM_FACES_DEFAULT = 1024;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [VAL_W-1:0] Q_ONE       = 48'd268435456;
  localparam logic [VAL_W-1:0] Q_HALF      = 48'd134217728;
  localparam logic [VAL_W-1:0] ALPHA_FIXED = 48'd80531;
  localparam logic [79:0]      LIM_POS     = 80'h7FFF_FFFF_FFFF;
  localparam logic [79:0]      LIM_NEG     = 80'h8000_0000_0000;

  localparam logic [CFG_IDX_W-1:0] CFG_WALL_RES  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TWO_DT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAR_TEMP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COND      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RHO_C     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_TURB  = 3'd5;

  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_MUL = 2'd2;
  localparam logic [1:0] ALU_DIV = 2'd3;

  typedef struct packed {
    logic [REG_W-1:0] wall_resistance;
    logic [REG_W-1:0] two_dt_over_capacity;
    logic [REG_W-1:0] far_side_temperature;
    logic [REG_W-1:0] conductivity;
    logic [REG_W-1:0] heat_capacity_density;
    logic             use_turbulent_field;
  } cfg_t;

  typedef struct packed {
    logic              is_load;
    logic [FACE_W-1:0] face;
    logic [VAL_W-1:0]  tc;
    logic [REG_W-1:0]  delta;
    logic [REG_W-1:0]  turb;
  } item_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic sat;
  } alu_rsp_t;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    logic             sat;
  } clamp_t;

  function automatic clamp_t clamp_mag(input logic [79:0] mag, input logic neg);
    clamp_t     r;
    logic [79:0] lim;
    logic [79:0] m;
    lim = neg ? LIM_NEG : LIM_POS;
    m = mag;
    r.sat = 1'b0;
    if (mag > lim) begin
      m = lim;
      r.sat = 1'b1;
    end
    r.val = neg ? (48'd0 - m[VAL_W-1:0]) : m[VAL_W-1:0];
    return r;
  endfunction

endpackage

>>> rtl/core/rcw_front.sv
`timescale 1ns / 1ps
module rcw_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [rcw_pkg::FACE_W-1:0] face_index,
  input  logic signed [rcw_pkg::VAL_W-1:0] cell_temperature,
  input  logic [rcw_pkg::REG_W-1:0] delta_coeff,
  input  logic [rcw_pkg::REG_W-1:0] turb_diffusivity,
  output logic                  q_valid,
  output rcw_pkg::item_t        q_item,
  input  logic                  q_pop
);
  import rcw_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  item_t          q [QUEUE_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [PW:0]    count;
  logic           push;
  item_t          item_in;

  assign in_ready = (count != (PW+1)'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_item   = q[rptr];

  always_comb begin
    item_in.is_load = operation;
    item_in.face    = face_index;
    item_in.tc      = cell_temperature;
    item_in.delta   = delta_coeff;
    item_in.turb    = turb_diffusivity;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (q_pop) rptr <= rptr + 1'b1;
      if (push && !q_pop) count <= count + 1'b1;
      else if (!push && q_pop) count <= count - 1'b1;
    end
  end
endmodule

>>> rtl/core/rcw_alu.sv
`timescale 1ns / 1ps
module rcw_alu (
  input  logic                      clk,
  input  logic                      rst,
  input  rcw_pkg::alu_req_t         req,
  input  logic [rcw_pkg::VAL_W-1:0] a,
  input  logic [rcw_pkg::VAL_W-1:0] b,
  output rcw_pkg::alu_rsp_t         rsp,
  output logic [rcw_pkg::VAL_W-1:0] y
);
  import rcw_pkg::*;

  logic        busy;
  logic [1:0]  opc;
  logic [6:0]  cnt;
  logic        neg;
  logic [96:0] acc;
  logic [47:0] ma;
  logic [47:0] mb;
  logic [48:0] rem;
  logic [75:0] quo;
  logic [75:0] numr;
  logic [47:0] ub;

  logic [47:0] mag_a;
  logic [47:0] mag_b;
  logic [48:0] sum;
  logic [48:0] sum_mag;
  logic [48:0] r2;
  logic [96:0] rnd;
  clamp_t      cl_add;
  clamp_t      cl_mul;
  clamp_t      cl_div;

  always_comb begin
    mag_a = a[47] ? (48'd0 - a) : a;
    mag_b = b[47] ? (48'd0 - b) : b;
    if (req.op == ALU_SUB) sum = {a[47], a} - {b[47], b};
    else sum = {a[47], a} + {b[47], b};
    sum_mag = sum[48] ? (49'd0 - sum) : sum;
    cl_add  = clamp_mag(80'(sum_mag), sum[48]);
    r2      = {rem[47:0], numr[75]};
    rnd     = acc + 97'(Q_HALF);
    cl_mul  = clamp_mag(80'(rnd[96:28]), neg);
    cl_div  = clamp_mag(80'(quo), neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
      rsp.sat  <= 1'b0;
    end else begin
      if (!busy && req.start) begin
        opc <= req.op;
        neg <= a[47] ^ b[47];
        case (req.op)
          ALU_ADD, ALU_SUB: begin
            y        <= cl_add.val;
            rsp.sat  <= cl_add.sat;
            rsp.done <= 1'b1;
          end
          ALU_MUL: begin
            ma       <= mag_a;
            mb       <= mag_b;
            acc      <= '0;
            cnt      <= 7'd3;
            busy     <= 1'b1;
            rsp.done <= 1'b0;
          end
          default: begin
            if (mag_b == '0) begin
              y        <= a[47] ? LIM_NEG[47:0] : LIM_POS[47:0];
              rsp.sat  <= 1'b1;
              rsp.done <= 1'b1;
            end else begin
              numr     <= {mag_a, 28'd0};
              ub       <= mag_b;
              rem      <= '0;
              quo      <= '0;
              cnt      <= 7'd76;
              busy     <= 1'b1;
              rsp.done <= 1'b0;
            end
          end
        endcase
      end else if (busy) begin
        if (cnt != '0) begin
          rsp.done <= 1'b0;
          cnt <= cnt - 1'b1;
          if (opc == ALU_MUL) begin
            acc <= (acc << 16) + 97'(ma * mb[47:32]);
            mb  <= mb << 16;
          end else begin
            numr <= numr << 1;
            if (r2 >= {1'b0, ub}) begin
              rem <= r2 - {1'b0, ub};
              quo <= {quo[74:0], 1'b1};
            end else begin
              rem <= r2;
              quo <= {quo[74:0], 1'b0};
            end
          end
        end else begin
          busy     <= 1'b0;
          rsp.done <= 1'b1;
          if (opc == ALU_MUL) begin
            y       <= cl_mul.val;
            rsp.sat <= cl_mul.sat;
          end else begin
            y       <= cl_div.val;
            rsp.sat <= cl_div.sat;
          end
        end
      end else begin
        rsp.done <= 1'b0;
      end
    end
  end
endmodule

>>> rtl/core/rcw_back.sv
`timescale 1ns / 1ps
module rcw_back #(
  parameter int unsigned NUM_FACES = rcw_pkg::NUM_FACES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  rcw_pkg::cfg_t             cfg,
  input  logic                      q_valid,
  input  rcw_pkg::item_t            q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rcw_pkg::FACE_W-1:0] face_index_out,
  output logic signed [rcw_pkg::VAL_W-1:0] wall_temperature,
  output logic                      saturated
);
  import rcw_pkg::*;

  localparam int unsigned AW = (NUM_FACES > 1) ? $clog2(NUM_FACES) : 1;
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [4:0] LAST_STEP = 5'd17;

  logic [VAL_W-1:0] mem [NUM_FACES];
  logic [VAL_W-1:0] rd_data;

  logic [1:0]       state;
  logic [4:0]       step;
  logic             issued;
  logic             sat_acc;
  item_t            cur;
  logic             in_range;
  logic [AW-1:0]    addr;

  logic [VAL_W-1:0] p, s, d, rair, t1, req_r, inv_r, hinv, av, bv, cv, ev, t2, num, sm, t3, den;
  logic [VAL_W-1:0] res;

  alu_req_t         areq;
  alu_rsp_t         arsp;
  logic [VAL_W-1:0] opa, opb, y, alpha, old;
  logic             fin_go;

  assign in_range = 32'(cur.face) < NUM_FACES;
  assign addr     = AW'(cur.face);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign alpha    = cfg.use_turbulent_field ? {1'b0, cur.turb} : ALPHA_FIXED;
  assign old      = in_range ? rd_data : '0;
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);

  always_comb begin
    areq.start = (state == S_RUN) && !issued;
    areq.op = ALU_ADD;
    opa = '0;
    opb = '0;
    case (step)
      5'd0:  begin areq.op = ALU_MUL; opa = {1'b0, cfg.heat_capacity_density}; opb = alpha; end
      5'd1:  begin areq.op = ALU_ADD; opa = {1'b0, cfg.conductivity}; opb = p; end
      5'd2:  begin areq.op = ALU_MUL; opa = {1'b0, cur.delta}; opb = s; end
      5'd3:  begin areq.op = ALU_DIV; opa = Q_ONE; opb = d; end
      5'd4:  begin areq.op = ALU_MUL; opa = {1'b0, cfg.wall_resistance}; opb = Q_HALF; end
      5'd5:  begin areq.op = ALU_ADD; opa = rair; opb = t1; end
      5'd6:  begin areq.op = ALU_DIV; opa = Q_ONE; opb = {1'b0, cfg.wall_resistance}; end
      5'd7:  begin areq.op = ALU_DIV; opa = Q_HALF; opb = req_r; end
      5'd8:  begin areq.op = ALU_DIV; opa = cur.tc; opb = req_r; end
      5'd9:  begin areq.op = ALU_SUB; opa = inv_r; opb = hinv; end
      5'd10: begin areq.op = ALU_MUL; opa = {1'b0, cfg.far_side_temperature}; opb = bv; end
      5'd11: begin areq.op = ALU_ADD; opa = av; opb = cv; end
      5'd12: begin areq.op = ALU_MUL; opa = {1'b0, cfg.two_dt_over_capacity}; opb = ev; end
      5'd13: begin areq.op = ALU_ADD; opa = old; opb = t2; end
      5'd14: begin areq.op = ALU_ADD; opa = inv_r; opb = hinv; end
      5'd15: begin areq.op = ALU_MUL; opa = {1'b0, cfg.two_dt_over_capacity}; opb = sm; end
      5'd16: begin areq.op = ALU_ADD; opa = Q_ONE; opb = t3; end
      5'd17: begin areq.op = ALU_DIV; opa = num; opb = den; end
      default: begin areq.op = ALU_ADD; end
    endcase
  end

  rcw_alu u_alu (
    .clk (clk),
    .rst (rst),
    .req (areq),
    .a   (opa),
    .b   (opb),
    .rsp (arsp),
    .y   (y)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_data <= mem[AW'(q_item.face)];
    end
    if (fin_go && in_range) begin
      mem[addr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur     <= q_item;
      res     <= q_item.tc;
      sat_acc <= 1'b0;
      step    <= '0;
    end
    if (state == S_RUN && arsp.done) begin
      sat_acc <= sat_acc | arsp.sat;
      step    <= step + 1'b1;
      case (step)
        5'd0:  p     <= y;
        5'd1:  s     <= y;
        5'd2:  d     <= y;
        5'd3:  rair  <= y;
        5'd4:  t1    <= y;
        5'd5:  req_r <= y;
        5'd6:  inv_r <= y;
        5'd7:  hinv  <= y;
        5'd8:  av    <= y;
        5'd9:  bv    <= y;
        5'd10: cv    <= y;
        5'd11: ev    <= y;
        5'd12: t2    <= y;
        5'd13: num   <= y;
        5'd14: sm    <= y;
        5'd15: t3    <= y;
        5'd16: den   <= y;
        default: res <= y;
      endcase
    end
    if (fin_go) begin
      face_index_out   <= cur.face;
      wall_temperature <= res;
      saturated        <= sat_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fin_go) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) state <= q_item.is_load ? S_FIN : S_RUN;
          issued <= 1'b0;
        end
        S_RUN: begin
          if (!issued) issued <= 1'b1;
          if (arsp.done) begin
            issued <= 1'b0;
            if (step == LAST_STEP) state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/rc_wall_temperature_update.sv
`timescale 1ns / 1ps
// Lumped RC wall model: one wall temperature per boundary face, loaded by a
// load transaction and advanced by an implicit Euler step on each update.
// Transactions enter a four-deep queue one per cycle while it has room and
// are worked off in order by a sequencer that drives one shared arithmetic
// unit. An update runs five bit-serial 76-step divisions through that unit
// besides its multiplies and adds (a zero divisor gives a saturated result);
// a load only stores its temperature. The back end takes one transaction at a
// time, so the queue fills under a stream of updates. The result register
// lets the next transaction start while a result waits.
// The wall store is undefined until each face is loaded.
module rc_wall_temperature_update #(
  parameter int unsigned NUM_FACES = rcw_pkg::NUM_FACES_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [rcw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcw_pkg::REG_W-1:0]    cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         operation,
  input  logic [rcw_pkg::FACE_W-1:0]   face_index,
  input  logic signed [rcw_pkg::VAL_W-1:0] cell_temperature,
  input  logic [rcw_pkg::REG_W-1:0]    delta_coeff,
  input  logic [rcw_pkg::REG_W-1:0]    turb_diffusivity,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [rcw_pkg::FACE_W-1:0]   face_index_out,
  output logic signed [rcw_pkg::VAL_W-1:0] wall_temperature,
  output logic                         saturated
);
  import rcw_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  logic  q_pop;
  item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wall_resistance       <= 47'd268435456;
      cfg.two_dt_over_capacity  <= 47'd2684355;
      cfg.far_side_temperature  <= 47'd80530636800;
      cfg.conductivity          <= 47'd268435456;
      cfg.heat_capacity_density <= 47'd268435456000;
      cfg.use_turbulent_field   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WALL_RES: cfg.wall_resistance       <= cfg_data;
        CFG_TWO_DT:   cfg.two_dt_over_capacity  <= cfg_data;
        CFG_FAR_TEMP: cfg.far_side_temperature  <= cfg_data;
        CFG_COND:     cfg.conductivity          <= cfg_data;
        CFG_RHO_C:    cfg.heat_capacity_density <= cfg_data;
        CFG_USE_TURB: cfg.use_turbulent_field   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  rcw_front u_front (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .face_index       (face_index),
    .cell_temperature (cell_temperature),
    .delta_coeff      (delta_coeff),
    .turb_diffusivity (turb_diffusivity),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop)
  );

  rcw_back #(.NUM_FACES(NUM_FACES)) u_back (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .face_index_out   (face_index_out),
    .wall_temperature (wall_temperature),
    .saturated        (saturated)
  );
endmodule

>>> rtl/core/rcw_checker.sv
`timescale 1ns / 1ps
module rcw_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [9:0]  face_index_out,
  input logic [47:0] wall_temperature,
  input logic        saturated
);
  a_reset_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
  a_reset_ready: assert property (@(posedge clk) rst |=> in_ready)
    else $error("queue not empty after reset");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(wall_temperature)
      && $stable(face_index_out) && $stable(saturated))
    else $error("stalled result changed");
endmodule

bind rc_wall_temperature_update rcw_checker u_chk (.*);

>>> test/tb_rc_wall_temperature_update.sv
`timescale 1ns / 1ps
module tb_rc_wall_temperature_update;
  import rcw_pkg::*;

  typedef struct {
    logic [FACE_W-1:0] face;
    logic [VAL_W-1:0]  temp;
    logic              sat;
  } wall_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [REG_W-1:0]      cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  operation;
  logic [FACE_W-1:0]     face_index;
  logic signed [VAL_W-1:0] cell_temperature;
  logic [REG_W-1:0]      delta_coeff;
  logic [REG_W-1:0]      turb_diffusivity;
  logic                  out_valid;
  logic                  out_ready;
  logic [FACE_W-1:0]     face_index_out;
  logic signed [VAL_W-1:0] wall_temperature;
  logic                  saturated;

  rc_wall_temperature_update dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
    .face_index(face_index), .cell_temperature(cell_temperature),
    .delta_coeff(delta_coeff), .turb_diffusivity(turb_diffusivity),
    .out_valid(out_valid), .out_ready(out_ready), .face_index_out(face_index_out),
    .wall_temperature(wall_temperature), .saturated(saturated)
  );

  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  cfg_t         wall_cfg;
  longint       wall_store [1024];
  bit           face_loaded [1024];
  bit           step_sat;
  wall_result_t pending_walls [$];
  int           error_count;
  bit           send_burst;
  bit           recv_burst;
  int           hold_req;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd100_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic bit [127:0] mag_of(longint v);
    return v < 0 ? 128'(-v) : 128'(v);
  endfunction

  function automatic longint sat_fit(bit [127:0] m, bit neg);
    bit [127:0] lim;
    lim = neg ? 128'h8000_0000_0000 : 128'h7FFF_FFFF_FFFF;
    if (m > lim) begin
      step_sat = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    return sat_fit(((mag_of(a) * mag_of(b)) + (128'd1 << 27)) >> 28, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint a, longint b);
    if (b == 0) begin
      step_sat = 1'b1;
      return a < 0 ? -(longint'(1) << 47) : (longint'(1) << 47) - 1;
    end
    return sat_fit((mag_of(a) << 28) / mag_of(b), (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_fit(longint s);
    return sat_fit(mag_of(s), s < 0);
  endfunction

  function automatic wall_result_t predict_wall(logic op, logic [FACE_W-1:0] face,
      logic signed [VAL_W-1:0] tc_in, logic [REG_W-1:0] delta, logic [REG_W-1:0] turb);
    wall_result_t r;
    longint tc, res_r, g, alpha, p, s, d, rair, req, inv_r, half_inv_req;
    longint a, b, c, e, num, sum, den, res;
    tc = longint'(tc_in);
    step_sat = 1'b0;
    if (op == OP_LOAD) begin
      res = tc;
    end else begin
      res_r = longint'(wall_cfg.wall_resistance);
      g = longint'(wall_cfg.two_dt_over_capacity);
      alpha = wall_cfg.use_turbulent_field ? longint'(turb) : longint'(ALPHA_FIXED);
      p = fx_mul(longint'(wall_cfg.heat_capacity_density), alpha);
      s = fx_fit(longint'(wall_cfg.conductivity) + p);
      d = fx_mul(longint'(delta), s);
      rair = fx_div(longint'(Q_ONE), d);
      req = fx_fit(rair + fx_mul(res_r, longint'(Q_HALF)));
      inv_r = fx_div(longint'(Q_ONE), res_r);
      half_inv_req = fx_div(longint'(Q_HALF), req);
      a = fx_div(tc, req);
      b = fx_fit(inv_r - half_inv_req);
      c = fx_mul(longint'(wall_cfg.far_side_temperature), b);
      e = fx_fit(a + c);
      num = fx_fit(wall_store[face] + fx_mul(g, e));
      sum = fx_fit(inv_r + half_inv_req);
      den = fx_fit(longint'(Q_ONE) + fx_mul(g, sum));
      res = fx_div(num, den);
    end
    wall_store[face] = res;
    face_loaded[face] = 1'b1;
    r.face = face;
    r.temp = res[VAL_W-1:0];
    r.sat = step_sat;
    return r;
  endfunction

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic logic [REG_W-1:0] rand47();
    return REG_W'({$urandom, $urandom});
  endfunction

  task automatic send_item(logic op, logic [FACE_W-1:0] face, logic signed [VAL_W-1:0] tc,
      logic [REG_W-1:0] delta, logic [REG_W-1:0] turb);
    int gap;
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    operation <= op;
    face_index <= face;
    cell_temperature <= tc;
    delta_coeff <= delta;
    turb_diffusivity <= turb;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    pending_walls.push_back(predict_wall(op, face, tc, delta, turb));
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_walls.size() != 0) @(posedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_WALL_RES: wall_cfg.wall_resistance = val;
      CFG_TWO_DT:   wall_cfg.two_dt_over_capacity = val;
      CFG_FAR_TEMP: wall_cfg.far_side_temperature = val;
      CFG_COND:     wall_cfg.conductivity = val;
      CFG_RHO_C:    wall_cfg.heat_capacity_density = val;
      CFG_USE_TURB: wall_cfg.use_turbulent_field = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_temp();
    case ($urandom_range(0, 3))
      0: return VAL_W'({$urandom, $urandom});
      1: return -48'sd1 * $urandom_range(0, 1000) <<< 20;
      default: return (48'($urandom_range(250, 350)) << 28) + 48'($urandom_range(0, 2**20));
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_delta();
    case ($urandom_range(0, 7))
      0: return '0;
      1, 2: return rand47();
      default: return 47'($urandom_range(1, 200)) << 28;
    endcase
  endfunction

  function automatic logic [REG_W-1:0] pick_turb();
    case ($urandom_range(0, 3))
      0: return rand47();
      1: return '0;
      default: return 47'($urandom_range(0, 400000));
    endcase
  endfunction

  task automatic run_stream(int count);
    logic [FACE_W-1:0] face;
    repeat (count) begin
      if ($urandom_range(0, 49) == 0) begin
        send_burst = ~send_burst;
        recv_burst = 1'($urandom_range(0, 1));
      end
      face = ($urandom_range(0, 3) == 0) ? FACE_W'($urandom_range(0, 7)) : FACE_W'($urandom);
      if (!face_loaded[face] || $urandom_range(0, 9) == 0)
        send_item(OP_LOAD, face, pick_temp(), rand47(), rand47());
      else
        send_item(OP_UPDATE, face, pick_temp(), pick_delta(), pick_turb());
    end
    send_burst = 1'b0;
  endtask

  task automatic test_directed();
    send_item(OP_LOAD, 10'd0, 48'sd300 <<< 28, '0, '0);
    send_item(OP_LOAD, 10'd1023, 48'sh8000_0000_0000, '1, '1);
    send_item(OP_LOAD, 10'd512, 48'sh7FFF_FFFF_FFFF, '0, '0);
    send_item(OP_UPDATE, 10'd0, 48'sd310 <<< 28, 47'd10 <<< 28, '0);
    send_item(OP_UPDATE, 10'd1023, 48'sd290 <<< 28, '0, '0);
    send_item(OP_UPDATE, 10'd512, 48'sh8000_0000_0000, '1, '1);
    send_item(OP_UPDATE, 10'd0, 48'sh7FFF_FFFF_FFFF, 47'd1, '0);
    send_item(OP_UPDATE, 10'd0, 48'sd0, 47'd10 <<< 28, '1);
    wait_idle();
    write_reg(CFG_USE_TURB, 47'd1);
    send_item(OP_UPDATE, 10'd0, 48'sd300 <<< 28, 47'd10 <<< 28, 47'd100000);
    send_item(OP_UPDATE, 10'd1023, 48'sd300 <<< 28, 47'd10 <<< 28, '1);
    send_item(OP_UPDATE, 10'd512, -48'sd5 <<< 28, '1, '0);
    send_item(OP_UPDATE, 10'd512, 48'sd300 <<< 28, 47'd1 <<< 28, 47'd80531);
    wait_idle();
  endtask

  task automatic test_config_phases();
    write_reg(CFG_USE_TURB, 47'd0);
    write_reg(CFG_WALL_RES, 47'd1);
    write_reg(CFG_TWO_DT, '0);
    write_reg(CFG_FAR_TEMP, '0);
    write_reg(CFG_COND, '0);
    write_reg(CFG_RHO_C, '0);
    run_stream(200);
    wait_idle();
    write_reg(CFG_WALL_RES, '1);
    write_reg(CFG_TWO_DT, '1);
    write_reg(CFG_FAR_TEMP, '1);
    write_reg(CFG_COND, '1);
    write_reg(CFG_RHO_C, '1);
    write_reg(CFG_USE_TURB, 47'd1);
    run_stream(200);
    wait_idle();
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_WALL_RES, 47'($urandom_range(1, 20)) << 27);
      write_reg(CFG_TWO_DT, 47'($urandom_range(0, 1 << 26)));
      write_reg(CFG_FAR_TEMP, 47'($urandom_range(250, 350)) << 28);
      write_reg(CFG_COND, 47'($urandom_range(0, 8)) << 27);
      write_reg(CFG_RHO_C, 47'($urandom_range(1, 2000)) << 28);
      write_reg(CFG_USE_TURB, 47'(ph & 1));
      run_stream(200);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    hold_req = 3000;
    send_burst = 1'b1;
    run_stream(30);
    wait_idle();
  endtask

  initial begin
    int stall;
    forever begin
      stall = draw_gap(recv_burst);
      if (hold_req > 0) begin
        stall = hold_req;
        hold_req = 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    wall_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_walls.size() == 0) begin
        $display("%0t: unexpected result face=%0d temp=%h", $time, face_index_out,
                 wall_temperature);
        error_count++;
      end else begin
        want = pending_walls.pop_front();
        if (face_index_out !== want.face) begin
          $display("%0t: face expected %0d actual %0d", $time, want.face, face_index_out);
          error_count++;
        end
        if (wall_temperature !== want.temp) begin
          $display("%0t: wall_temperature expected %h actual %h", $time, want.temp,
                   wall_temperature);
          error_count++;
        end
        if (saturated !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $time, want.sat, saturated);
          error_count++;
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = 1'b0;
    face_index = '0;
    cell_temperature = '0;
    delta_coeff = '0;
    turb_diffusivity = '0;
    out_ready = 1'b0;
    error_count = 0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    hold_req = 0;
    wall_cfg.wall_resistance = 47'd268435456;
    wall_cfg.two_dt_over_capacity = 47'd2684355;
    wall_cfg.far_side_temperature = 47'd80530636800;
    wall_cfg.conductivity = 47'd268435456;
    wall_cfg.heat_capacity_density = 47'd268435456000;
    wall_cfg.use_turbulent_field = 1'b0;
    foreach (wall_store[i]) begin
      wall_store[i] = 0;
      face_loaded[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_config_phases();
    test_backpressure();
    wait_idle();
    repeat (500) @(posedge clk);
    if (error_count == 0 && pending_walls.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/rcw_pkg.sv
rtl/core/rcw_front.sv
rtl/core/rcw_alu.sv
rtl/core/rcw_back.sv
rtl/core/rc_wall_temperature_update.sv
rtl/core/rcw_checker.sv
test/tb_rc_wall_temperature_update.sv
